[rtl/core/event_calendar_sorted_queue_top_assert.svh]
// assertion macros for the event calendar sorted queue
// no dependencies; included inside the top module, which checks itself
`ifndef EVENT_CALENDAR_SORTED_QUEUE_TOP_ASSERT_SVH
`define EVENT_CALENDAR_SORTED_QUEUE_TOP_ASSERT_SVH

// same-cycle implication under synchronous reset
`define ECSQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under synchronous reset
`define ECSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/ecsq_pkg.sv]
// shared widths, status codes and the broadcast command of the event calendar
// no dependencies
package ecsq_pkg;

   localparam int TIME_W    = 48;
   localparam int TAG_W     = 16;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 5;
   localparam int DEPTH_DEF = 16;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic              ins;
      logic              rem;
      logic [TIME_W-1:0] ev_time;
      logic [TAG_W-1:0]  ev_tag;
   } ecsq_cmd_type;

endpackage

[rtl/core/ecsq_cell.sv]
// one slot of the sorted chain: holds a time and tag, shifts with its neighbors
// depends on ecsq_pkg
module ecsq_cell
   import ecsq_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic              clock,
   input  ecsq_cmd_type      cmd,
   input  logic [CNT_W-1:0]  count,
   input  logic              prev_later,
   input  logic [TIME_W-1:0] prev_time,
   input  logic [TAG_W-1:0]  prev_tag,
   input  logic [TIME_W-1:0] next_time,
   input  logic [TAG_W-1:0]  next_tag,
   output logic              later,
   output logic [TIME_W-1:0] slot_time,
   output logic [TAG_W-1:0]  slot_tag
);

   logic [TIME_W-1:0] time_ff, time_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              occupied;

   // free slots count as later so the new entry lands at the tail
   assign occupied = CNT_W'(IDX) < count;
   assign later    = !occupied || (time_ff > cmd.ev_time);

   always_comb begin
      time_in = time_ff;
      tag_in  = tag_ff;
      if (cmd.ins && later) begin
         if (!prev_later) begin
            time_in = cmd.ev_time;
            tag_in  = cmd.ev_tag;
         end else begin
            time_in = prev_time;
            tag_in  = prev_tag;
         end
      end else if (cmd.rem) begin
         time_in = next_time;
         tag_in  = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      tag_ff  <= tag_in;
   end

   assign slot_time = time_ff;
   assign slot_tag  = tag_ff;

endmodule

[rtl/core/event_calendar_sorted_queue_top.sv]
// event calendar: sorted future-event queue built as a chain of slot cells
// depends on ecsq_pkg, ecsq_cell and event_calendar_sorted_queue_top_assert.svh
//
// usage
//   request channel (req_valid/req_ready): req_mode 0 inserts req_event_time
//   and req_event_tag, req_mode 1 removes the earliest entry
//   response channel (rsp_valid/rsp_ready): exactly one response per request,
//   with status, the removed entry, system time, head and fill level
//   every cell compares its time with the broadcast request in parallel and
//   shifts toward its neighbor in the same cycle, so one request completes
//   per clock: rsp_valid rises in the cycle after acceptance
//   throughput is one request per cycle while the receiver keeps up
//   equal times leave in arrival order; insert into a full queue is dropped
//   with status full, remove on empty returns status empty
//   the response sits in an output register; req_ready stays high while that
//   register is empty or being drained, so a stalled receiver holds at most
//   one finished response and then backpressures the request side
//   reset empties the queue and clears the system time;
//   slot contents are not cleared since only occupied slots are ever read
module event_calendar_sorted_queue_top
   import ecsq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [TIME_W-1:0]   req_event_time,
   input  logic [TAG_W-1:0]    req_event_tag,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [TIME_W-1:0]   rsp_removed_time,
   output logic [TAG_W-1:0]    rsp_removed_tag,
   output logic [TIME_W-1:0]   rsp_current_time,
   output logic                rsp_head_valid,
   output logic [TIME_W-1:0]   rsp_head_time,
   output logic [COUNT_W-1:0]  rsp_entry_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // chain taps
   logic [TIME_W-1:0] cell_time [DEPTH];
   logic [TAG_W-1:0]  cell_tag  [DEPTH];
   logic [DEPTH-1:0]  cell_later;

   ecsq_cmd_type cmd;
   logic         accept;
   logic         full;
   logic         empty;

   // control and state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] sim_time_ff, sim_time_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // response register
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [TIME_W-1:0]   rem_time_ff, rem_time_in;
   logic [TAG_W-1:0]    rem_tag_ff, rem_tag_in;
   logic [TIME_W-1:0]   head_time_ff, head_time_in;
   logic [CNT_W+COUNT_W-1:0] count_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = count_ff == CNT_W'(DEPTH);
   assign empty     = count_ff == '0;

   // broadcast command: rejected requests leave the chain alone
   always_comb begin
      cmd.ins     = accept && (req_mode == MODE_INSERT) && !full;
      cmd.rem     = accept && (req_mode == MODE_REMOVE) && !empty;
      cmd.ev_time = req_event_time;
      cmd.ev_tag  = req_event_tag;
   end

   // the chain of slots, head at index zero
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic              prev_later;
      logic [TIME_W-1:0] prev_time;
      logic [TAG_W-1:0]  prev_tag;
      logic [TIME_W-1:0] next_time;
      logic [TAG_W-1:0]  next_tag;

      if (i == 0) begin : g_head
         assign prev_later = 1'b0;
         assign prev_time  = req_event_time;
         assign prev_tag   = req_event_tag;
      end else begin : g_body
         assign prev_later = cell_later[i-1];
         assign prev_time  = cell_time[i-1];
         assign prev_tag   = cell_tag[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_time = '0;
         assign next_tag  = '0;
      end else begin : g_inner
         assign next_time = cell_time[i+1];
         assign next_tag  = cell_tag[i+1];
      end

      ecsq_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .prev_later (prev_later),
         .prev_time  (prev_time),
         .prev_tag   (prev_tag),
         .next_time  (next_time),
         .next_tag   (next_tag),
         .later      (cell_later[i]),
         .slot_time  (cell_time[i]),
         .slot_tag   (cell_tag[i])
      );
   end

   // fill level, system time and the response for this step
   always_comb begin
      count_in     = count_ff;
      sim_time_in  = sim_time_ff;
      status_in    = status_ff;
      rem_time_in  = rem_time_ff;
      rem_tag_in   = rem_tag_ff;
      head_time_in = head_time_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         rem_time_in  = '0;
         rem_tag_in   = '0;
         if (req_mode == MODE_INSERT) begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in    = count_ff - 1'b1;
               rem_time_in = cell_time[0];
               rem_tag_in  = cell_tag[0];
               sim_time_in = cell_time[0];
            end
         end

         // head after the step, zero when empty
         if (count_in == '0) begin
            head_time_in = '0;
         end else if (cmd.ins && cell_later[0]) begin
            head_time_in = req_event_time;
         end else if (cmd.rem) begin
            head_time_in = cell_time[1];
         end else begin
            head_time_in = cell_time[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sim_time_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sim_time_ff  <= sim_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      rem_time_ff  <= rem_time_in;
      rem_tag_ff   <= rem_tag_in;
      head_time_ff <= head_time_in;
   end

   assign count_ext = {{COUNT_W{1'b0}}, count_ff};

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_removed_time = rem_time_ff;
   assign rsp_removed_tag  = rem_tag_ff;
   assign rsp_current_time = sim_time_ff;
   assign rsp_head_valid   = !empty;
   assign rsp_head_time    = head_time_ff;
   assign rsp_entry_count  = count_ext[COUNT_W-1:0];

   `include "event_calendar_sorted_queue_top_assert.svh"

   `ECSQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "fill level above depth")
   `ECSQ_ASSERT_NEXT(a_insert_grows, clock, reset, cmd.ins, count_ff == $past(count_ff) + 1'b1, "insert did not grow the queue")
   `ECSQ_ASSERT_NEXT(a_empty_remove, clock, reset, accept && (req_mode == MODE_REMOVE) && empty, rsp_valid && (rsp_status == ST_EMPTY) && $stable(sim_time_ff), "remove on empty not flagged")
   `ECSQ_ASSERT_NOW(a_head_sorted, clock, reset, count_ff >= CNT_W'(2), cell_time[0] <= cell_time[1], "head slots out of order")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for the event calendar sorted queue, one request at a time
// depends on ecsq_pkg and event_calendar_sorted_queue_top; a local calendar predicts responses
module tb_top;
   import ecsq_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_PCT = 15;
   localparam int MAX_REPORTS = 40;

   // one response as the block should present it
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TIME_W-1:0]   removed_time;
      logic [TAG_W-1:0]    removed_tag;
      logic [TIME_W-1:0]   current_time;
      logic                head_valid;
      logic [TIME_W-1:0]   head_time;
      logic [COUNT_W-1:0]  entry_count;
   } calendar_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_mode = MODE_INSERT;
   logic [TIME_W-1:0]   req_event_time = '0;
   logic [TAG_W-1:0]    req_event_tag = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [TIME_W-1:0]   rsp_removed_time;
   logic [TAG_W-1:0]    rsp_removed_tag;
   logic [TIME_W-1:0]   rsp_current_time;
   logic                rsp_head_valid;
   logic [TIME_W-1:0]   rsp_head_time;
   logic [COUNT_W-1:0]  rsp_entry_count;

   // local copy of the calendar: sorted slots, fill level and system time
   logic [TIME_W-1:0] cal_time [QUEUE_DEPTH];
   logic [TAG_W-1:0]  cal_tag  [QUEUE_DEPTH];
   int                cal_fill = 0;
   logic [TIME_W-1:0] cal_now = '0;

   calendar_rsp_type expected_rsp [$];
   int               mismatch_count = 0;
   int               cycle_count = 0;

   // steady turns off random idling on both sides
   bit steady = 1'b0;
   // receiver hold-off: requested by a test, counted down by the receiver process
   int hold_off_start = 0;
   int hold_off_left = 0;

   event_calendar_sorted_queue_top #(
      .DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_event_time  (req_event_time),
      .req_event_tag   (req_event_tag),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_removed_time(rsp_removed_time),
      .rsp_removed_tag (rsp_removed_tag),
      .rsp_current_time(rsp_current_time),
      .rsp_head_valid  (rsp_head_valid),
      .rsp_head_time   (rsp_head_time),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run guard: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_rsp.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // advance the local calendar by one request and return the response it implies
   function automatic calendar_rsp_type step_calendar(input logic mode,
                                                      input logic [TIME_W-1:0] ev_time,
                                                      input logic [TAG_W-1:0] ev_tag);
      calendar_rsp_type r;
      int               pos;
      r = '0;
      r.status = ST_OK;
      if (mode == MODE_INSERT) begin
         if (cal_fill >= QUEUE_DEPTH) begin
            // full: request dropped, state untouched
            r.status = ST_FULL;
         end else begin
            // insert before the first strictly later entry, so ties keep arrival order
            pos = cal_fill;
            for (int i = 0; i < cal_fill; i++) begin
               if (pos == cal_fill && cal_time[i] > ev_time) begin
                  pos = i;
               end
            end
            for (int i = cal_fill; i > pos; i--) begin
               cal_time[i] = cal_time[i-1];
               cal_tag[i]  = cal_tag[i-1];
            end
            cal_time[pos] = ev_time;
            cal_tag[pos]  = ev_tag;
            cal_fill++;
         end
      end else begin
         if (cal_fill == 0) begin
            // empty: nothing removed, system time holds
            r.status = ST_EMPTY;
         end else begin
            r.removed_time = cal_time[0];
            r.removed_tag  = cal_tag[0];
            cal_now = cal_time[0];
            for (int i = 1; i < cal_fill; i++) begin
               cal_time[i-1] = cal_time[i];
               cal_tag[i-1]  = cal_tag[i];
            end
            cal_fill--;
         end
      end
      r.current_time = cal_now;
      r.head_valid   = (cal_fill > 0);
      r.head_time    = (cal_fill > 0) ? cal_time[0] : '0;
      r.entry_count  = COUNT_W'(cal_fill);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                  cycle_count, what, got, want);
      end
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // response checker: every accepted response against the oldest prediction
   always @(posedge clock) begin
      calendar_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_status, '0);
         end else begin
            want = expected_rsp[0];
            expected_rsp.delete(0);
            check_field("status", rsp_status, want.status);
            check_field("removed_time", rsp_removed_time, want.removed_time);
            check_field("removed_tag", rsp_removed_tag, want.removed_tag);
            check_field("current_time", rsp_current_time, want.current_time);
            check_field("head_valid", rsp_head_valid, want.head_valid);
            check_field("head_time", rsp_head_time, want.head_time);
            check_field("entry_count", rsp_entry_count, want.entry_count);
         end
      end
   end

   // receiver: random stalls, ready whenever steady and no hold-off runs, and long hold-offs on demand
   always @(posedge clock) begin
      if (hold_off_start > 0) begin
         hold_off_left = hold_off_start;
         hold_off_start = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // one request: optional idle gap, then hold valid until the handshake,
   // then predict at the edge where it was taken
   task automatic send_request(input logic mode, input logic [TIME_W-1:0] ev_time,
                               input logic [TAG_W-1:0] ev_tag);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_event_time <= ev_time;
      req_event_tag  <= ev_tag;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      expected_rsp.insert(expected_rsp.size(), step_calendar(mode, ev_time, ev_tag));
   endtask

   // times: a narrow band for plenty of ties, full range, and the two extremes
   function automatic logic [TIME_W-1:0] random_event_time();
      case ($urandom_range(0, 3))
         0: return TIME_W'($urandom_range(0, 7));
         1: return '1;
         2: return TIME_W'($urandom_range(0, 1)) ? '0 : TIME_W'({$urandom, $urandom});
         default: return TIME_W'({$urandom, $urandom});
      endcase
   endfunction

   // remove before anything was inserted; the ignored fields carry all ones
   task automatic test_remove_on_empty();
      send_request(MODE_REMOVE, '1, '1);
   endtask

   // largest and smallest time and tag, an alternating pattern, then drain past empty
   task automatic test_time_extremes();
      send_request(MODE_INSERT, '1, '1);
      send_request(MODE_INSERT, '0, '0);
      send_request(MODE_INSERT, {TIME_W/2{2'b01}}, {TAG_W/2{2'b10}});
      repeat (4) send_request(MODE_REMOVE, {TIME_W/2{2'b10}}, {TAG_W/2{2'b01}});
   endtask

   // equal times must leave in arrival order, an earlier time jumps ahead
   task automatic test_equal_times();
      send_request(MODE_INSERT, TIME_W'(100), TAG_W'(1));
      send_request(MODE_INSERT, TIME_W'(50), TAG_W'(2));
      send_request(MODE_INSERT, TIME_W'(100), TAG_W'(3));
      send_request(MODE_INSERT, TIME_W'(100), TAG_W'(4));
      repeat (4) send_request(MODE_REMOVE, '0, '0);
   endtask

   // phases biased toward filling (and overflowing), draining, or a balanced mix
   task automatic test_random_mix(input int n_requests);
      int   sent;
      int   insert_pct;
      int   phase_len;
      logic mode;
      sent = 0;
      while (sent < n_requests) begin
         case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 20;
            default: insert_pct = 50;
         endcase
         phase_len = $urandom_range(10, 40);
         repeat (phase_len) begin
            mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
            send_request(mode, random_event_time(), TAG_W'($urandom));
            sent++;
         end
      end
   endtask

   // receiver stalls long while requests keep coming, so req_ready must drop
   task automatic test_backpressure();
      hold_off_start = 80;
      test_random_mix(30);
   endtask

   // back-to-back traffic with no idling on either side
   task automatic test_streaming();
      steady = 1'b1;
      test_random_mix(200);
      steady = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_remove_on_empty();
      test_time_extremes();
      test_equal_times();
      test_backpressure();
      test_streaming();
      test_random_mix(1100);

      req_valid <= 1'b0;
      // everything sent: wait for the last responses, then let the bench idle before the verdict
      while (expected_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ecsq_pkg.sv
rtl/core/ecsq_cell.sv
rtl/core/event_calendar_sorted_queue_top.sv
bench/tb_top.sv
